### design/plcm_pkg.sv
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared types and constants for the piecewise linear colormap.
// ----------------------------------------------------------------------------
package plcm_pkg;

  // breakpoint table depth, fixed by the 4-bit slot and 5-bit count fields
  localparam int MAX_ENTRIES = 16;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic REG_USE_GRADIENT = 1'b0;
  localparam logic REG_ENTRY_COUNT  = 1'b1;

  // result kinds handed from front to back
  localparam logic [1:0] KIND_ZERO  = 2'd0;
  localparam logic [1:0] KIND_COLOR = 2'd1;
  localparam logic [1:0] KIND_BLEND = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [32:0] t;
    logic [32:0] d;
  } job_t;

endpackage

### design/plcm_front.sv
// ----------------------------------------------------------------------------
// plcm_front
// Accepts items, writes loads into the table and scans it for each sample.
// ----------------------------------------------------------------------------
module plcm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                use_gradient,
  input  logic [4:0]          entry_count,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [3:0]          entry_index,
  input  logic signed [31:0]  entry_key,
  input  logic [31:0]         entry_color,
  input  logic signed [31:0]  pixel_value,
  output logic                job_valid,
  output plcm_pkg::job_t      job,
  input  logic                job_full
);
  localparam int MAX_ENTRIES = plcm_pkg::MAX_ENTRIES;
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // table stores, one read per cycle except while a result waits
  logic signed [31:0] keys   [MAX_ENTRIES];
  logic [31:0]        colors [MAX_ENTRIES];

  logic               busy;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      lim;
  logic signed [31:0] v;
  logic               grad;
  logic signed [31:0] rd_key, prev_key;
  logic [31:0]        rd_color, prev_color;
  logic               rd_ok;
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      cnt_sat;

  assign in_stall = busy;
  assign cnt_sat = (entry_count > 5'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(entry_count);

  // table write on load
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && req_type == plcm_pkg::REQ_LOAD
        && 32'(entry_index) < 32'(MAX_ENTRIES)) begin
      keys[entry_index[IW-1:0]]   <= entry_key;
      colors[entry_index[IW-1:0]] <= entry_color;
    end
  end

  logic hit, last;
  assign hit  = rd_ok && (v <= rd_key);
  assign last = rd_ok && (rd_idx + 1'b1 >= lim);

  // registered table read, one entry a cycle; held while the result waits
  always_ff @(posedge clk) begin
    if (!(hit || last)) begin
      rd_key   <= keys[idx[IW-1:0]];
      rd_color <= colors[idx[IW-1:0]];
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      rd_ok <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= 1'b0;
      if (!busy) begin
        if (in_valid && req_type == plcm_pkg::REQ_PIXEL) begin
          v <= pixel_value;
          grad <= use_gradient;
          lim <= cnt_sat;
          idx <= '0;
          rd_idx <= '0;
          if (cnt_sat == '0) begin
            if (!job_full) begin
              job_valid <= 1'b1;
              job.kind <= plcm_pkg::KIND_ZERO;
            end else begin
              busy <= 1'b1;
              rd_ok <= 1'b0;
            end
          end else begin
            busy  <= 1'b1;
            rd_ok <= 1'b0;
          end
        end
      end else if (lim == '0) begin
        if (!job_full) begin
          job_valid <= 1'b1;
          job.kind <= plcm_pkg::KIND_ZERO;
          busy <= 1'b0;
        end
      end else if (!rd_ok) begin
        rd_ok  <= 1'b1;
        rd_idx <= idx;
        idx    <= idx + 1'b1;
      end else if (hit || last) begin
        if (!job_full) begin
          job_valid <= 1'b1;
          busy  <= 1'b0;
          rd_ok <= 1'b0;
          job.c0 <= prev_color;
          job.c1 <= rd_color;
          job.t  <= 33'(signed'({v[31], v}) - signed'({prev_key[31], prev_key}));
          job.d  <= 33'(signed'({rd_key[31], rd_key}) - signed'({prev_key[31], prev_key}));
          if (!hit)
            job.kind <= plcm_pkg::KIND_ZERO;
          else if (!grad || v == rd_key || rd_idx == '0)
            job.kind <= plcm_pkg::KIND_COLOR;
          else
            job.kind <= plcm_pkg::KIND_BLEND;
        end
      end else begin
        prev_key   <= rd_key;
        prev_color <= rd_color;
        rd_idx <= idx;
        idx    <= idx + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) job_valid |-> !$past(job_full));
  assert property (@(posedge clk) disable iff (rst) busy && rd_ok |-> rd_idx < lim)
    else $error("scan index past limit");
  assert property (@(posedge clk) disable iff (rst)
    job_valid && job.kind == plcm_pkg::KIND_BLEND |-> !job.d[32] && job.d != '0)
    else $error("bad blend divisor");
endmodule

### design/plcm_queue.sv
// ----------------------------------------------------------------------------
// plcm_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module plcm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  input  plcm_pkg::job_t  wr_job,
  output logic            full,
  output logic            rd_valid,
  output plcm_pkg::job_t  rd_job,
  input  logic            rd_take
);
  plcm_pkg::job_t mem [4];
  logic [2:0] wp, rp;

  assign rd_valid = (wp != rp);
  // leave room for the item already in flight in the front
  assign full = (3'(wp - rp) >= 3'd3);
  assign rd_job = mem[rp[1:0]];

  always_ff @(posedge clk) begin
    if (wr_valid) mem[wp[1:0]] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (wr_valid) wp <= wp + 1'b1;
      if (rd_take && rd_valid) rp <= rp + 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) 3'(wp - rp) <= 3'd4)
    else $error("queue overflow");
endmodule

### design/plcm_back.sv
// ----------------------------------------------------------------------------
// plcm_back
// Serial divider per channel; emits one rgba item per job.
// ----------------------------------------------------------------------------
module plcm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  plcm_pkg::job_t  job,
  output logic            job_take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_color
);
  localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_OUT = 2'd2;

  logic [1:0]  state;
  logic [1:0]  ch;
  logic [5:0]  bitn;
  logic [40:0] num;
  logic [40:0] rem;
  logic [40:0] quo;
  logic [32:0] dd;
  logic [7:0]  a, b;
  logic        down;
  logic [31:0] c0, c1, res;
  logic [32:0] tt;
  logic [40:0] rem_sh;
  logic [40:0] rem_sub;

  assign job_take = (state == S_IDLE) && job_valid;
  assign rem_sh   = {rem[39:0], num[40]};
  assign rem_sub  = rem_sh - 41'(dd);
  assign out_valid = (state == S_OUT);
  assign out_color = res;

  always_comb begin
    a = c0[31 - 8*ch -: 8];
    b = c1[31 - 8*ch -: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (job_valid) begin
          c0 <= job.c0; c1 <= job.c1; tt <= job.t; dd <= job.d;
          ch <= 2'd0; bitn <= 6'd0;
          unique case (job.kind)
            plcm_pkg::KIND_BLEND: begin
              state <= S_DIV;
              num <= '0;
              rem <= '0;
            end
            plcm_pkg::KIND_COLOR: begin res <= job.c1; state <= S_OUT; end
            default: begin res <= '0; state <= S_OUT; end
          endcase
        end
        S_DIV: begin
          if (bitn == 6'd0) begin
            // load numerator t*|c1-c0| (+d-1 when descending)
            down <= (b < a);
            num  <= (b >= a) ? 41'(tt) * 41'(b - a)
                             : 41'(tt) * 41'(a - b) + 41'(dd) - 41'd1;
            rem  <= '0;
            quo  <= '0;
            bitn <= 6'd1;
          end else if (bitn <= 6'd41) begin
            if (rem_sub[40] == 1'b0) begin
              rem <= rem_sub;
              quo <= {quo[39:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[39:0], 1'b0};
            end
            num  <= {num[39:0], 1'b0};
            bitn <= bitn + 1'b1;
          end else begin
            res[31 - 8*ch -: 8] <= down ? 8'(a - quo[7:0]) : 8'(a + quo[7:0]);
            bitn <= 6'd0;
            if (ch == 2'd3) state <= S_OUT;
            ch <= ch + 1'b1;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("output dropped");
  assert property (@(posedge clk) disable iff (rst) job_take |=> state != S_IDLE)
    else $error("job not started");
endmodule

### design/piecewise_linear_colormap_top.sv
// the front scans the table entry by entry until the hit slot or the last entry (no scan
// when the count is zero), then hands its job through the queue to the back, which shows
// it in S_OUT; a blend first runs a 41-step restoring divider on each channel in turn
// the front stalls new items while it scans a sample or waits for queue room; the back
// takes a new job only in S_IDLE; a four-job queue sits between them; loads give no output
// rst is synchronous: clears config registers, queue and control; the table is not cleared
// ----------------------------------------------------------------------------
// piecewise_linear_colormap_top
// Maps samples to rgba through a breakpoint table, step or gradient.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [3:0]         entry_index,
  input  logic signed [31:0] entry_key,
  input  logic [7:0]         entry_red,
  input  logic [7:0]         entry_green,
  input  logic [7:0]         entry_blue,
  input  logic [7:0]         entry_alpha,
  input  logic signed [31:0] pixel_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha
);
  logic use_gradient;
  logic [4:0] entry_count;
  logic fj_valid, q_full, q_valid, q_take;
  plcm_pkg::job_t fj, qj;
  logic [31:0] color;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_gradient <= 1'b0;
      entry_count  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == plcm_pkg::REG_USE_GRADIENT) use_gradient <= cfg_data[0];
      else entry_count <= cfg_data[4:0];
    end
  end

  plcm_front u_front (
    .clk, .rst, .use_gradient, .entry_count, .in_valid, .in_stall,
    .req_type, .entry_index, .entry_key,
    .entry_color({entry_red, entry_green, entry_blue, entry_alpha}),
    .pixel_value, .job_valid(fj_valid), .job(fj), .job_full(q_full)
  );

  plcm_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_job(fj), .full(q_full),
    .rd_valid(q_valid), .rd_job(qj), .rd_take(q_take)
  );

  plcm_back u_back (
    .clk, .rst, .job_valid(q_valid), .job(qj), .job_take(q_take),
    .out_valid, .out_stall, .out_color(color)
  );

  assign out_red   = color[31:24];
  assign out_green = color[23:16];
  assign out_blue  = color[15:8];
  assign out_alpha = color[7:0];
endmodule

### sim/tb_piecewise_linear_colormap_top.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_colormap_top
// Self-checking bench for the colormap: loads breakpoint tables, maps samples
// in step and gradient mode and checks every rgba result against a predictor.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_colormap_top;

  localparam int TABLE_DEPTH = plcm_pkg::MAX_ENTRIES;
  localparam int DRAIN_CYCLES = 250;
  localparam int STALL_LIMIT = 6000;

  typedef struct {
    logic              req;
    logic [3:0]        idx;
    logic signed [31:0] key;
    logic [7:0]        r, g, b, a;
    logic signed [31:0] pix;
  } req_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [3:0] entry_index = '0;
  logic signed [31:0] entry_key = '0;
  logic [7:0] entry_red = '0, entry_green = '0, entry_blue = '0, entry_alpha = '0;
  logic signed [31:0] pixel_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  piecewise_linear_colormap_top DUT (.*);

  // predictor state
  logic signed [31:0] ramp_keys [TABLE_DEPTH];
  logic [31:0]        ramp_colors [TABLE_DEPTH];
  logic               ramp_gradient = 1'b0;
  logic [4:0]         ramp_count = '0;

  req_item_t pending_items[$];
  logic [31:0] expected_rgba[$];
  req_item_t cur_item;
  int mismatches = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int idle_cycles = 0;
  int send_wait = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] c0, logic [7:0] c1,
                                               longint unsigned t, longint unsigned d);
    longint unsigned q;
    if (c1 >= c0) begin
      q = (t * longint'(c1 - c0)) / d;
      return c0 + q[7:0];
    end
    q = (t * longint'(c0 - c1) + d - 1) / d;
    return c0 - q[7:0];
  endfunction

  // expected rgba for one sample against the current table
  function automatic logic [31:0] map_sample(logic signed [31:0] v);
    int n;
    longint signed k0, k1, sv;
    longint unsigned t, d;
    logic [31:0] res;
    n = (ramp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(ramp_count);
    sv = v;
    for (int i = 0; i < n; i++) begin
      k1 = ramp_keys[i];
      if (sv > k1) continue;
      if (!ramp_gradient || sv == k1 || i == 0) return ramp_colors[i];
      k0 = ramp_keys[i-1];
      t = sv - k0;
      d = k1 - k0;
      for (int ch = 0; ch < 4; ch++)
        res[31-8*ch -: 8] = blend_channel(ramp_colors[i-1][31-8*ch -: 8],
                                          ramp_colors[i][31-8*ch -: 8], t, d);
      return res;
    end
    return '0;
  endfunction

  // driver: predicts each accepted item, then offers the next
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_item.req == plcm_pkg::REQ_LOAD) begin
          ramp_keys[cur_item.idx] = cur_item.key;
          ramp_colors[cur_item.idx] = {cur_item.r, cur_item.g, cur_item.b, cur_item.a};
        end else begin
          expected_rgba.push_back(map_sample(cur_item.pix));
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_item.req;
          entry_index <= cur_item.idx;
          entry_key <= cur_item.key;
          entry_red <= cur_item.r;
          entry_green <= cur_item.g;
          entry_blue <= cur_item.b;
          entry_alpha <= cur_item.a;
          pixel_value <= cur_item.pix;
          if (send_gaps) send_wait = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off after some results
  int stall_left = 0;
  int hold_left = 0;
  int results_seen = 0;
  bit held = 1'b0;
  always @(posedge clk) begin
    if (out_valid && !out_stall) results_seen++;
    if (!held && results_seen == 60) begin
      held = 1'b1;
      hold_left = 900;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (recv_gaps && $urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // monitor: compare each result with the oldest expected color
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_rgba.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h%h%h%h",
                                       out_red, out_green, out_blue, out_alpha);
      end else begin
        want = expected_rgba.pop_front();
        if ({out_red, out_green, out_blue, out_alpha} !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rgba mismatch: expected %h actual %h%h%h%h",
                     want, out_red, out_green, out_blue, out_alpha);
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == plcm_pkg::REG_USE_GRADIENT) ramp_gradient = data[0];
    else ramp_count = data[4:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_items.size() != 0 || in_valid
                              || expected_rgba.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(logic req, logic [3:0] idx, logic [31:0] key,
                           logic [31:0] color, logic [31:0] pix);
    req_item_t it;
    it.req = req;
    it.idx = idx;
    it.key = key;
    {it.r, it.g, it.b, it.a} = color;
    it.pix = pix;
    pending_items.push_back(it);
  endtask

  task automatic push_pixel(logic [31:0] pix);
    push_item(plcm_pkg::REQ_PIXEL, 4'($urandom), $urandom, $urandom, pix);
  endtask

  // random table: sorted most of the time, narrow spans sometimes
  task automatic load_random_table();
    logic signed [31:0] k [TABLE_DEPTH];
    logic signed [31:0] tmp;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < TABLE_DEPTH; i++)
      k[i] = (mode < 3) ? 32'($urandom_range(0, 4000)) - 2000 : $urandom;
    if (mode != 9)
      for (int i = 1; i < TABLE_DEPTH; i++)
        for (int j = i; j > 0 && k[j-1] > k[j]; j--) begin
          tmp = k[j];
          k[j] = k[j-1];
          k[j-1] = tmp;
        end
    @(negedge clk);
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_item(plcm_pkg::REQ_LOAD, 4'(i), k[i], $urandom, $urandom);
    wait_idle();
  endtask

  initial begin
    int sel;
    logic signed [31:0] v;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: extreme keys and colors at both ends
    cfg_write(plcm_pkg::REG_USE_GRADIENT, 32'd0);
    cfg_write(plcm_pkg::REG_ENTRY_COUNT, 32'd16);
    @(negedge clk);
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_item(plcm_pkg::REQ_LOAD, 4'(i),
                (i == 15) ? 32'h7FFF_FF00 : 32'((i - 8) * 32'h1000_0000),
                (i == 0) ? 32'h0000_0000 : (i == 15) ? 32'hFFFF_FFFF : $urandom,
                $urandom);
    wait_idle();
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) cfg_write(plcm_pkg::REG_USE_GRADIENT, 32'hFFFF_FFFF);
      @(negedge clk);
      push_pixel(32'h8000_0000);
      push_pixel(32'h7FFF_FFFF);
      push_pixel(32'h3000_0000);
      push_pixel(32'h3000_0001);
      push_pixel(32'h2FFF_FFFF);
      push_pixel(32'h7FFF_FEFF);
      push_pixel(32'h0000_0000);
      push_pixel(32'h8000_0001);
      wait_idle();
    end
    // empty table, then counts above the table
    cfg_write(plcm_pkg::REG_ENTRY_COUNT, 32'd0);
    @(negedge clk);
    push_pixel(32'h0000_0000);
    wait_idle();
    cfg_write(plcm_pkg::REG_ENTRY_COUNT, 32'hFFFF_FFFF);
    @(negedge clk);
    push_pixel(32'h1234_5678);
    wait_idle();
    cfg_write(plcm_pkg::REG_ENTRY_COUNT, 32'd17);

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      send_gaps = (ph != 2);
      recv_gaps = (ph != 3);
      load_random_table();
      cfg_write(plcm_pkg::REG_USE_GRADIENT, $urandom);
      sel = $urandom_range(0, 9);
      cfg_write(plcm_pkg::REG_ENTRY_COUNT, (sel == 0) ? 32'($urandom_range(17, 31)) :
                (sel == 1) ? 32'd1 : {$urandom} & 32'hFFFF_FFE0
                | 32'($urandom_range(1, 16)));
      @(negedge clk);
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          v = ramp_keys[$urandom_range(0, TABLE_DEPTH - 1)]
              + 32'($urandom_range(0, 8)) - 32'sd4;
          push_pixel(v);
        end else if ($urandom_range(0, 9) == 0) begin
          // load-item noise into a slot the scan never reaches is not possible;
          // reload an existing slot with its own contents instead
          sel = $urandom_range(0, TABLE_DEPTH - 1);
          push_item(plcm_pkg::REQ_LOAD, 4'(sel), ramp_keys[sel], ramp_colors[sel],
                    $urandom);
        end else begin
          push_pixel($urandom);
        end
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/plcm_pkg.sv
design/plcm_front.sv
design/plcm_queue.sv
design/plcm_back.sv
design/piecewise_linear_colormap_top.sv
sim/tb_piecewise_linear_colormap_top.sv
